// File: sv/sacts_pkg.sv
package sacts_pkg;

    // Geometry of the store
    localparam int NUM_SETS    = 256;
    localparam int NUM_WAYS    = 4;
    localparam int BLOCK_BYTES = 64;
    localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);

    // Operation codes
    localparam logic [2:0] OP_FIND   = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_TOUCH  = 3'd3;
    localparam logic [2:0] OP_VICTIM = 3'd4;

    // Replacement policy codes
    localparam logic [1:0] POL_LRU    = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request word, launch row read
        logic exec;     // row data ready: update row, load response
    } cmd_t;

endpackage

// File: sv/sacts_ctrl.sv
module sacts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sacts_pkg::cmd_t   cmd
);
    import sacts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // Take a word only when idle and the response slot is free or draining
    assign req_stall   = !((state_reg == S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign cmd.capture = req_valid && !req_stall;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign rsp_valid   = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.exec)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: sv/sacts_dp.sv
module sacts_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  sacts_pkg::cmd_t   cmd,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic [2:0]        op,
    input  logic [31:0]       addr,
    input  logic [7:0]        set_index,
    input  logic [1:0]        way_index,
    input  logic [31:0]       tag,
    input  logic [2:0]        status,
    output logic              found,
    output logic [7:0]        set_out,
    output logic [1:0]        way_out,
    output logic [2:0]        status_out,
    output logic [31:0]       tag_out
);
    import sacts_pkg::*;

    typedef struct packed {
        logic [31:0]      tag;
        logic [2:0]       status;
        logic [WAY_W-1:0] rank;
    } way_entry_t;

    typedef way_entry_t [NUM_WAYS-1:0] row_t;

    // Row memory, one row per set; row valid bits stand in for the reset clear
    row_t              mem [NUM_SETS];
    logic [NUM_SETS-1:0] row_valid_reg;
    row_t              rd_reg;
    logic              rd_valid_reg;

    logic [1:0]        policy_reg;
    logic [15:0]       lfsr_reg;

    // Latched request word
    logic [2:0]        op_reg;
    logic [SET_W-1:0]  row_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [31:0]       tag_reg;
    logic [2:0]        status_reg;
    logic [31:0]       ftag_reg;

    // Response registers
    logic              found_reg;
    logic [7:0]        set_out_reg;
    logic [1:0]        way_out_reg;
    logic [2:0]        status_out_reg;
    logic [31:0]       tag_out_reg;

    logic [SET_W-1:0]  rd_addr;
    row_t              cur_row;
    row_t              new_row;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              any_free;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  tail_way;
    logic              move_head;
    logic [WAY_W-1:0]  old_rank;
    logic [15:0]       lfsr_step;
    logic              lfsr_adv;
    logic              row_we;
    logic [WAY_W-1:0]  victim_way;

    // Find uses the address's set field, everything else the set index
    assign rd_addr = (op == OP_FIND) ? addr[OFFSET_W +: SET_W] : set_index;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_LRU;
        else if (cfg_wr_en)
            policy_reg <= cfg_wr_data;
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            row_reg    <= rd_addr;
            way_reg    <= way_index;
            tag_reg    <= tag;
            status_reg <= status;
            ftag_reg   <= {addr[31:OFFSET_W], {OFFSET_W{1'b0}}};
        end
    end

    // Memory port: registered read on capture, write on exec
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_reg <= mem[rd_addr];
        if (row_we)
            mem[row_reg] <= new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                rd_valid_reg <= row_valid_reg[rd_addr];
            if (row_we)
                row_valid_reg[row_reg] <= 1'b1;
        end
    end

    // Row as seen by the operation; untouched rows read as reset value
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rd_valid_reg)
                cur_row[w] = rd_reg[w];
            else
            begin
                cur_row[w].tag    = '0;
                cur_row[w].status = '0;
                cur_row[w].rank   = WAY_W'(w);
            end
        end
    end

    // Way searches, lowest way wins
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        tail_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (cur_row[w].status != 3'd0 && cur_row[w].tag == ftag_reg)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (cur_row[w].status == 3'd0)
            begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
            if (cur_row[w].rank == WAY_W'(NUM_WAYS - 1))
                tail_way = WAY_W'(w);
        end
    end

    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[15:1]};

    // Victim choice
    always_comb
    begin
        lfsr_adv = 1'b0;
        if (any_free)
            victim_way = free_way;
        else if (policy_reg == POL_LRU || policy_reg == POL_FIFO)
            victim_way = tail_way;
        else
        begin
            victim_way = lfsr_step[WAY_W-1:0];
            lfsr_adv   = (op_reg == OP_VICTIM);
        end
    end

    // Row update: move to head and tag write
    always_comb
    begin
        old_rank  = cur_row[way_reg].rank;
        move_head = 1'b0;
        if (op_reg == OP_SET)
            move_head = (policy_reg == POL_FIFO) && (cur_row[way_reg].tag != tag_reg);
        else if (op_reg == OP_TOUCH)
            move_head = (policy_reg == POL_LRU);
        new_row = cur_row;
        if (move_head)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
                if (cur_row[w].rank < old_rank)
                    new_row[w].rank = cur_row[w].rank + WAY_W'(1);
            new_row[way_reg].rank = '0;
        end
        if (op_reg == OP_SET)
        begin
            new_row[way_reg].tag    = tag_reg;
            new_row[way_reg].status = status_reg;
        end
    end

    assign row_we = cmd.exec && (op_reg == OP_SET || op_reg == OP_TOUCH);

    // Pseudo-random source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lfsr_reg <= LFSR_SEED;
        else if (cmd.exec && lfsr_adv)
            lfsr_reg <= lfsr_step;
    end

    // Response word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            found_reg      <= 1'b0;
            set_out_reg    <= '0;
            way_out_reg    <= '0;
            status_out_reg <= '0;
            tag_out_reg    <= '0;
            case (op_reg)
                OP_FIND:
                begin
                    found_reg   <= hit;
                    set_out_reg <= 8'(row_reg);
                    if (hit)
                    begin
                        way_out_reg    <= 2'(hit_way);
                        status_out_reg <= cur_row[hit_way].status;
                    end
                end
                OP_GET:
                begin
                    status_out_reg <= cur_row[way_reg].status;
                    tag_out_reg    <= cur_row[way_reg].tag;
                end
                OP_VICTIM:
                begin
                    way_out_reg <= 2'(victim_way);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign found      = found_reg;
    assign set_out    = set_out_reg;
    assign way_out    = way_out_reg;
    assign status_out = status_out_reg;
    assign tag_out    = tag_out_reg;

endmodule

// File: sv/set_assoc_cache_tag_store_unit.sv
// Set-associative tag and state store, 256 sets of 4 ways.
// Request channel (req_valid / req_stall) carries one operation word:
// find, set, get, touch or choose victim. Response channel
// (rsp_valid / rsp_stall) returns exactly one word per request.
// A word is taken on a clock edge with valid high and stall low.
// The set row is read into a register at the taking edge; in the execute
// state the ways are compared, the row is written back and the response
// register is loaded, together with rsp_valid.
// A new request is not taken while one executes: the controller stalls
// requests in its execute state, while the row read at capture is written back.
// A stalled response holds its register; a new request is taken once
// the pending response is taken, in the same cycle at the earliest.
// Reset clears all ways to invalid with tag 0, ranks to way order,
// the random source to its seed and the policy to LRU, at once through
// per-set valid bits, so requests are taken right after reset.
// cfg_wr_en/cfg_wr_data write the replacement policy; write it only
// while no request is in flight.
module set_assoc_cache_tag_store_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  op,
    input  logic [31:0] addr,
    input  logic [7:0]  set_index,
    input  logic [1:0]  way_index,
    input  logic [31:0] tag,
    input  logic [2:0]  status,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        found,
    output logic [7:0]  set_out,
    output logic [1:0]  way_out,
    output logic [2:0]  status_out,
    output logic [31:0] tag_out
);
    import sacts_pkg::*;

    cmd_t cmd;

    sacts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    sacts_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .addr        (addr),
        .set_index   (set_index),
        .way_index   (way_index),
        .tag         (tag),
        .status      (status),
        .found       (found),
        .set_out     (set_out),
        .way_out     (way_out),
        .status_out  (status_out),
        .tag_out     (tag_out)
    );

    // A taken request is executed in the very next cycle
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.exec)
        else $error("request not executed after capture");

    // Execution never overwrites a pending response
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !rsp_valid)
        else $error("response overwritten");

    // Execution always produces a response
    a_exec_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> rsp_valid)
        else $error("execution gave no response");

endmodule

// File: tb/set_assoc_cache_tag_store_unit_tb.sv
`timescale 1ns / 100ps

module set_assoc_cache_tag_store_unit_tb;
    import sacts_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] OP_RSVD5   = 3'd5;
    localparam logic [2:0] OP_RSVD6   = 3'd6;
    localparam logic [2:0] OP_RSVD7   = 3'd7;
    localparam logic [1:0] POL_CODE3  = 2'd3;
    localparam int         ENTRIES    = NUM_SETS * NUM_WAYS;
    localparam int         WDOG_LIMIT = 2000;
    localparam int         PHASES     = 9;
    localparam int         PHASE_OPS  = 200;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [7:0]  set_index;
        logic [1:0]  way_index;
        logic [31:0] tag;
        logic [2:0]  status;
    } tag_op_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  set_out;
        logic [1:0]  way_out;
        logic [2:0]  status_out;
        logic [31:0] tag_out;
    } store_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = POL_LRU;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  op = OP_FIND;
    logic [31:0] addr = '0;
    logic [7:0]  set_index = '0;
    logic [1:0]  way_index = '0;
    logic [31:0] tag = '0;
    logic [2:0]  status = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic        found;
    logic [7:0]  set_out;
    logic [1:0]  way_out;
    logic [2:0]  status_out;
    logic [31:0] tag_out;

    set_assoc_cache_tag_store_unit u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .addr        (addr),
        .set_index   (set_index),
        .way_index   (way_index),
        .tag         (tag),
        .status      (status),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .set_out     (set_out),
        .way_out     (way_out),
        .status_out  (status_out),
        .tag_out     (tag_out)
    );

    always #1 clk = ~clk;

    // Shadow copy of the tag store
    logic [31:0] shadow_tag  [ENTRIES];
    logic [2:0]  shadow_stat [ENTRIES];
    logic [1:0]  shadow_rank [ENTRIES];
    logic [15:0] shadow_lfsr;
    logic [1:0]  policy_now;

    tag_op_t    pending_ops [$];
    store_rsp_t awaited_rsp [$];
    int         words_queued = 0;
    int         words_taken = 0;
    int         rsp_done = 0;
    int         mismatch_cnt = 0;
    int         hit_cnt = 0;
    int         idle_cycles = 0;
    int         send_idle = 21;
    int         recv_idle = 59;

    // Random stimulus locality
    logic [7:0]  hot_sets [8];
    logic [17:0] tag_hi [4];

    tag_op_t    drv_word;
    tag_op_t    seen_word;
    store_rsp_t want;
    store_rsp_t got;

    function automatic void promote_way(input int base, input int way);
        logic [1:0] old;
        old = shadow_rank[base + way];
        for (int w = 0; w < NUM_WAYS; w++)
            if (shadow_rank[base + w] < old)
                shadow_rank[base + w] = shadow_rank[base + w] + 2'd1;
        shadow_rank[base + way] = 2'd0;
    endfunction

    function automatic logic [1:0] choose_victim(input int base);
        logic fb;
        for (int w = 0; w < NUM_WAYS; w++)
            if (shadow_stat[base + w] == 3'd0)
                return w[1:0];
        if (policy_now == POL_LRU || policy_now == POL_FIFO)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
                if (shadow_rank[base + w] == 2'(NUM_WAYS - 1))
                    return w[1:0];
            return 2'd0;
        end
        fb = shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5];
        shadow_lfsr = {fb, shadow_lfsr[15:1]};
        return shadow_lfsr[1:0];
    endfunction

    // Expected response; updates the shadow store as the block would
    function automatic store_rsp_t tag_store_response(input tag_op_t w);
        store_rsp_t r;
        int         base;
        int         idx;
        logic [7:0]  fset;
        logic [31:0] ftag;
        r    = '0;
        base = int'(w.set_index) * NUM_WAYS;
        idx  = base + int'(w.way_index);
        case (w.op)
            OP_FIND:
            begin
                fset = w.addr[OFFSET_W +: SET_W];
                ftag = w.addr & ~32'(BLOCK_BYTES - 1);
                r.set_out = fset;
                for (int k = 0; k < NUM_WAYS; k++)
                begin
                    if (!r.found && shadow_stat[fset * NUM_WAYS + k] != 3'd0 &&
                        shadow_tag[fset * NUM_WAYS + k] == ftag)
                    begin
                        r.found      = 1'b1;
                        r.way_out    = k[1:0];
                        r.status_out = shadow_stat[fset * NUM_WAYS + k];
                    end
                end
            end
            OP_SET:
            begin
                if (policy_now == POL_FIFO && shadow_tag[idx] != w.tag)
                    promote_way(base, int'(w.way_index));
                shadow_tag[idx]  = w.tag;
                shadow_stat[idx] = w.status;
            end
            OP_GET:
            begin
                r.status_out = shadow_stat[idx];
                r.tag_out    = shadow_tag[idx];
            end
            OP_TOUCH:
            begin
                if (policy_now == POL_LRU)
                    promote_way(base, int'(w.way_index));
            end
            OP_VICTIM:
                r.way_out = choose_victim(base);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic tag_op_t mk_word(input logic [2:0] o, input logic [31:0] a,
                                        input logic [7:0] s, input logic [1:0] w,
                                        input logic [31:0] t, input logic [2:0] st);
        tag_op_t x;
        x.op        = o;
        x.addr      = a;
        x.set_index = s;
        x.way_index = w;
        x.tag       = t;
        x.status    = st;
        return x;
    endfunction

    // Mostly well-formed tags on a few hot sets so finds hit and sets fill
    function automatic tag_op_t random_word();
        tag_op_t     x;
        int          pick;
        logic [7:0]  s;
        pick = $urandom_range(99);
        s = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : hot_sets[$urandom_range(7)];
        x = mk_word(OP_FIND, $urandom, s, 2'($urandom_range(3)), $urandom,
                    3'($urandom_range(7)));
        if ($urandom_range(4) != 0)
            x.tag = {tag_hi[$urandom_range(3)], s, 6'd0};
        x.status = ($urandom_range(5) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        if (pick < 32)
        begin
            x.op = OP_FIND;
            if ($urandom_range(4) != 0)
                x.addr = {tag_hi[$urandom_range(3)], s, 6'($urandom)};
        end
        else if (pick < 58)
            x.op = OP_SET;
        else if (pick < 70)
            x.op = OP_GET;
        else if (pick < 82)
            x.op = OP_TOUCH;
        else if (pick < 97)
            x.op = OP_VICTIM;
        else
            x.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        return x;
    endfunction

    task automatic queue_word(input tag_op_t x);
        pending_ops.push_back(x);
        words_queued++;
    endtask

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (rsp_done < words_queued);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_policy(input logic [1:0] p);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        policy_now = p;
    endtask

    // Request driver: payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                drv_word = pending_ops.pop_front();
                req_valid <= 1'b1;
                op        <= drv_word.op;
                addr      <= drv_word.addr;
                set_index <= drv_word.set_index;
                way_index <= drv_word.way_index;
                tag       <= drv_word.tag;
                status    <= drv_word.status;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < recv_idle);
    end

    // Monitor: check responses, then predict newly taken requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_done++;
                got = {found, set_out, way_out, status_out, tag_out};
                if (awaited_rsp.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected response word: found=%0d set=%0d way=%0d st=%0d tag=%h",
                                 got.found, got.set_out, got.way_out, got.status_out,
                                 got.tag_out);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (want.found)
                        hit_cnt++;
                    if (got.found != want.found || got.set_out != want.set_out ||
                        got.way_out != want.way_out || got.status_out != want.status_out ||
                        got.tag_out != want.tag_out)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch at word %0d: exp found=%0d set=%0d way=%0d st=%0d tag=%h, got found=%0d set=%0d way=%0d st=%0d tag=%h",
                                     rsp_done, want.found, want.set_out, want.way_out,
                                     want.status_out, want.tag_out, got.found, got.set_out,
                                     got.way_out, got.status_out, got.tag_out);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                words_taken++;
                seen_word = mk_word(op, addr, set_index, way_index, tag, status);
                awaited_rsp.push_back(tag_store_response(seen_word));
            end
            // Watchdog on handshake progress
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WDOG_LIMIT);
                $display("set_assoc_cache_tag_store_unit_tb: errors");
                $finish;
            end
        end
    end

    // Stimulus and phase sequencing
    initial
    begin
        logic [1:0]  policy_seq [PHASES];
        logic [31:0] dup_tag;
        policy_seq = '{POL_LRU, POL_FIFO, POL_RANDOM, POL_CODE3, POL_LRU, POL_RANDOM,
                       POL_FIFO, POL_CODE3, POL_LRU};
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_tag[i]  = '0;
            shadow_stat[i] = '0;
            shadow_rank[i] = 2'(i % NUM_WAYS);
        end
        shadow_lfsr = LFSR_SEED;
        policy_now  = POL_LRU;
        for (int i = 0; i < 4; i++)
            tag_hi[i] = 18'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_policy(POL_LRU);

        // Directed words under LRU
        dup_tag = {18'h2AAAA, 8'd5, 6'd0};
        queue_word(mk_word(OP_FIND, 32'd0, 8'd0, 2'd0, 32'd0, 3'd0));       // zero tag, invalid
        queue_word(mk_word(OP_GET, 32'd0, 8'd0, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_VICTIM, 32'd0, 8'd0, 2'd0, 32'd0, 3'd0));     // empty set
        queue_word(mk_word(OP_SET, 32'd0, 8'd255, 2'd3, 32'hFFFF_FFC0, 3'd7));
        queue_word(mk_word(OP_FIND, 32'hFFFF_FFFF, 8'd0, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_GET, 32'd0, 8'd255, 2'd3, 32'd0, 3'd0));
        queue_word(mk_word(OP_SET, 32'd0, 8'd5, 2'd0, {18'h11111, 8'd5, 6'd0}, 3'd1));
        queue_word(mk_word(OP_SET, 32'd0, 8'd5, 2'd1, dup_tag, 3'd2));
        queue_word(mk_word(OP_SET, 32'd0, 8'd5, 2'd2, dup_tag, 3'd3));
        queue_word(mk_word(OP_SET, 32'd0, 8'd5, 2'd3, {18'h3FFFF, 8'd5, 6'd0}, 3'd4));
        queue_word(mk_word(OP_FIND, dup_tag | 32'h3F, 8'd0, 2'd0, 32'd0, 3'd0)); // lowest way
        queue_word(mk_word(OP_VICTIM, 32'd0, 8'd5, 2'd0, 32'd0, 3'd0));     // tail way
        queue_word(mk_word(OP_TOUCH, 32'd0, 8'd5, 2'd3, 32'd0, 3'd0));
        queue_word(mk_word(OP_VICTIM, 32'd0, 8'd5, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_SET, 32'd0, 8'd5, 2'd1, dup_tag, 3'd0));      // invalidate
        queue_word(mk_word(OP_FIND, dup_tag, 8'd0, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_VICTIM, 32'd0, 8'd5, 2'd0, 32'd0, 3'd0));     // lowest invalid
        queue_word(mk_word(OP_RSVD5, 32'hFFFF_FFFF, 8'd255, 2'd3, 32'hFFFF_FFFF, 3'd7));
        queue_word(mk_word(OP_RSVD6, 32'hFFFF_FFFF, 8'd255, 2'd3, 32'hFFFF_FFFF, 3'd7));
        queue_word(mk_word(OP_RSVD7, 32'hFFFF_FFFF, 8'd255, 2'd3, 32'hFFFF_FFFF, 3'd7));
        queue_word(mk_word(OP_TOUCH, 32'd0, 8'd0, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_SET, 32'd0, 8'd0, 2'd0, 32'd0, 3'd7));
        queue_word(mk_word(OP_FIND, 32'h0000_003F, 8'd0, 2'd0, 32'd0, 3'd0));
        queue_word(mk_word(OP_SET, 32'd0, 8'd128, 2'd2, 32'hFFFF_FFFF, 3'd5));
        queue_word(mk_word(OP_GET, 32'd0, 8'd128, 2'd2, 32'd0, 3'd0));
        wait_quiet();

        // Random phases: policy changes only while quiet
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 3)
            begin
                send_idle = 59;
                recv_idle = 21;
            end
            else if (ph == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_policy(policy_seq[ph]);
            for (int i = 0; i < 8; i++)
                hot_sets[i] = 8'($urandom);
            for (int i = 0; i < PHASE_OPS; i++)
                queue_word(random_word());
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        if (awaited_rsp.size() != 0)
        begin
            mismatch_cnt++;
            $display("%0d expected responses never arrived", awaited_rsp.size());
        end
        $display("covered %0d operation words, %0d responses, %0d find hits",
                 words_taken, rsp_done, hit_cnt);
        $display("policies LRU, FIFO, random and code 3 under three idle mixes, %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("set_assoc_cache_tag_store_unit_tb: clean");
        else
            $display("set_assoc_cache_tag_store_unit_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/sacts_pkg.sv
sv/sacts_ctrl.sv
sv/sacts_dp.sv
sv/set_assoc_cache_tag_store_unit.sv
tb/set_assoc_cache_tag_store_unit_tb.sv
